// ===== sv/apba_pkg.sv =====
package apba_pkg;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_REL,
    ST_DONE
  } apba_state_t;

  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [1:0] GRP_ONE   = 2'd0;
  localparam logic [1:0] GRP_TWO   = 2'd1;
  localparam logic [1:0] GRP_FOUR  = 2'd2;
  localparam logic [1:0] GRP_EIGHT = 2'd3;

  localparam logic [7:0] BYTE_FULL = 8'hFF;

  // Control from the sequencer into the row update logic.
  typedef struct packed {
    logic       release_op;
    logic [1:0] code;
    logic [2:0] rel_byte;
    logic [2:0] rel_bit;
  } upd_ctrl_t;

  // Status back from the row update logic.
  typedef struct packed {
    logic [2:0] byte_sel;
    logic [2:0] bit_pos;
    logic [3:0] avail;
  } upd_stat_t;

  typedef struct packed {
    logic       found;
    logic [2:0] pos;
  } grp_hit_t;

  function automatic logic [7:0] group_mask(input logic [1:0] code);
    logic [7:0] m;
    unique case (code)
      GRP_ONE:   m = 8'h01;
      GRP_TWO:   m = 8'h03;
      GRP_FOUR:  m = 8'h0F;
      GRP_EIGHT: m = 8'hFF;
      default:   m = 8'h01;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] align_mask(input logic [1:0] code);
    logic [2:0] a;
    unique case (code)
      GRP_ONE:   a = 3'b000;
      GRP_TWO:   a = 3'b001;
      GRP_FOUR:  a = 3'b011;
      GRP_EIGHT: a = 3'b111;
      default:   a = 3'b000;
    endcase
    return a;
  endfunction

  // Bit n is set when the byte holds a free aligned group of 2**n pages.
  function automatic logic [3:0] byte_avail(input logic [7:0] b);
    logic [3:0] a;
    a[0] = (b != BYTE_FULL);
    a[1] = (b[1:0] == 2'b00) || (b[3:2] == 2'b00) || (b[5:4] == 2'b00) ||
           (b[7:6] == 2'b00);
    a[2] = (b[3:0] == 4'h0) || (b[7:4] == 4'h0);
    a[3] = (b == 8'h00);
    return a;
  endfunction

  // Lowest aligned free group of the requested size inside one byte.
  function automatic grp_hit_t find_group(input logic [7:0] b, input logic [1:0] code);
    grp_hit_t   r;
    logic [7:0] m;
    logic [2:0] a;
    m = group_mask(code);
    a = align_mask(code);
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if (((3'(i) & a) == 3'b000) && (((b >> i) & m) == 8'h00)) begin
        r.found = 1'b1;
        r.pos   = 3'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/apba_row_upd.sv =====
module apba_row_upd
  import apba_pkg::*;
(
  input  logic [63:0] row_in,
  input  upd_ctrl_t   ctrl,
  output logic [63:0] row_out,
  output upd_stat_t   stat
);

  logic [7:0][3:0] av_in;
  logic [7:0][3:0] av_out;
  logic [2:0]      acq_byte;
  logic [2:0]      byte_idx;
  logic [7:0]      cur;
  logic [7:0]      new_byte;
  logic [15:0]     shifted;
  grp_hit_t        hit;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      av_in[k] = byte_avail(row_in[k*8 +: 8]);
    end
    // The summary guarantees that some byte of this row fits an acquire.
    acq_byte = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (av_in[k][ctrl.code]) begin
        acq_byte = 3'(k);
      end
    end
  end

  assign byte_idx = ctrl.release_op ? ctrl.rel_byte : acq_byte;
  assign cur      = row_in[byte_idx*8 +: 8];
  assign hit      = find_group(cur, ctrl.code);

  always_comb begin
    if (ctrl.release_op) begin
      // Group bits that would fall past the top of the byte are dropped.
      shifted  = {8'h00, group_mask(ctrl.code)} << ctrl.rel_bit;
      new_byte = cur & ~shifted[7:0];
    end else begin
      shifted  = {8'h00, group_mask(ctrl.code)} << hit.pos;
      new_byte = cur | shifted[7:0];
    end
    row_out = row_in;
    row_out[byte_idx*8 +: 8] = new_byte;
    for (int k = 0; k < 8; k++) begin
      av_out[k] = byte_avail(row_out[k*8 +: 8]);
    end
    stat.avail = '0;
    for (int k = 0; k < 8; k++) begin
      stat.avail = stat.avail | av_out[k];
    end
    stat.byte_sel = acq_byte;
    stat.bit_pos  = hit.pos;
  end

endmodule

// ===== sv/aligned_page_bitmap_allocator_core.sv =====
// Channel   Direction  tdata                                   tuser
// s_axis    in         [1:0] group_code, [16:2] release_page    kind
// m_axis    out        [14:0] first_page                        granted
//
// The map sits in a memory of 8-byte rows; a summary memory keeps four bits per row,
// 16 rows to an entry, flagging a free group of 1, 2, 4 or 8 pages. An acquire reads k
// summary entries (1 .. ceil(MAP_BYTES/128)); a release that falls past the map leaves
// it unchanged. After reset a pass over every row writes the reserved pattern with
// s_axis_tready low. A stalled m_axis holds its result while the next request is
// accepted and processed.
module aligned_page_bitmap_allocator_core
  import apba_pkg::*;
#(
  parameter int MAP_BYTES           = 4096,
  parameter int LOW_RESERVED_BYTES  = 8,
  parameter int HIGH_RESERVED_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [1:0] group_code, [16:2] release_page, [23:17] zero
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [14:0] first_page, [15] zero
  output logic        m_axis_tuser    // [0] granted
);

  localparam int ROWS     = (MAP_BYTES + 7) / 8;
  localparam int SUMS     = (ROWS + 15) / 16;
  localparam int SUM_AW   = (SUMS > 1) ? $clog2(SUMS) : 1;
  localparam int ROW_AW   = SUM_AW + 4;
  localparam int ROWS_PAD = SUMS * 16;
  localparam int PW       = ROW_AW + 6;
  localparam int LOW_C    = (LOW_RESERVED_BYTES > MAP_BYTES) ? MAP_BYTES : LOW_RESERVED_BYTES;
  localparam int HIGH_C   = (HIGH_RESERVED_BYTES > MAP_BYTES) ? MAP_BYTES : HIGH_RESERVED_BYTES;
  localparam logic [31:0] LOW_LIM    = 32'(LOW_C);
  localparam logic [31:0] HIGH_START = 32'(MAP_BYTES - HIGH_C);
  localparam logic [31:0] MAP_LIM    = 32'(MAP_BYTES);
  localparam logic [ROW_AW-1:0] INIT_LAST = ROW_AW'(ROWS_PAD - 1);
  localparam logic [SUM_AW-1:0] SCAN_LAST = SUM_AW'(SUMS - 1);

  logic [63:0] map_mem [ROWS_PAD];
  logic [63:0] sum_mem [SUMS];

  apba_state_t state, state_next;

  logic [ROW_AW-1:0] init_cnt;
  logic [63:0]       sum_acc;
  logic [63:0]       sum_acc_next;
  logic [SUM_AW-1:0] scan_idx;
  logic [ROW_AW-1:0] row_addr;
  logic              op_kind;
  logic [1:0]        op_code;
  logic [14:0]       op_page;
  logic              res_granted;
  logic [14:0]       res_page;
  logic              out_valid;
  logic              out_granted;
  logic [14:0]       out_page;

  logic              map_we, sum_we;
  logic [ROW_AW-1:0] map_wa, map_ra;
  logic [SUM_AW-1:0] sum_wa, sum_ra;
  logic [63:0]       map_wd, sum_wd, map_q, sum_q;

  logic              in_kind;
  logic [1:0]        in_code;
  logic [14:0]       in_page;
  logic              accept;
  logic              rel_in_map;
  logic [ROW_AW+8:0] rel_ext;
  logic [ROW_AW-1:0] rel_row;

  logic [63:0]       init_row;
  logic [3:0]        init_avail;
  logic [15:0]       cand;
  logic              scan_hit;
  logic [3:0]        hit_row;

  upd_ctrl_t         upd_ctrl;
  upd_stat_t         upd_stat;
  logic [63:0]       row_new;
  logic [63:0]       sum_upd;
  logic [PW+14:0]    page_ext;
  logic              out_free;

  assign in_kind = s_axis_tuser;
  assign in_code = s_axis_tdata[1:0];
  assign in_page = s_axis_tdata[16:2];
  assign accept  = s_axis_tvalid && s_axis_tready;

  assign rel_in_map = (32'(in_page[14:3]) < MAP_LIM);
  assign rel_ext    = {{ROW_AW{1'b0}}, in_page[14:6]};
  assign rel_row    = rel_ext[ROW_AW-1:0];

  assign out_free = !out_valid || m_axis_tready;

  // Reserved pattern for the row being initialized; bytes past the map read as full.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      if ((32'({init_cnt, 3'(k)}) < LOW_LIM) || (32'({init_cnt, 3'(k)}) >= HIGH_START)) begin
        init_row[k*8 +: 8] = BYTE_FULL;
      end else begin
        init_row[k*8 +: 8] = 8'h00;
      end
    end
    init_avail = '0;
    for (int k = 0; k < 8; k++) begin
      init_avail = init_avail | byte_avail(init_row[k*8 +: 8]);
    end
    sum_acc_next = sum_acc;
    sum_acc_next[init_cnt[3:0]*4 +: 4] = init_avail;
  end

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      cand[j] = sum_q[j*4 + int'(op_code)];
    end
    hit_row = 4'd0;
    for (int j = 15; j >= 0; j--) begin
      if (cand[j]) begin
        hit_row = 4'(j);
      end
    end
  end
  assign scan_hit = |cand;

  assign upd_ctrl.release_op = (op_kind == KIND_RELEASE);
  assign upd_ctrl.code       = op_code;
  assign upd_ctrl.rel_byte   = op_page[5:3];
  assign upd_ctrl.rel_bit    = op_page[2:0];

  apba_row_upd u_row_upd (
    .row_in  (map_q),
    .ctrl    (upd_ctrl),
    .row_out (row_new),
    .stat    (upd_stat)
  );

  always_comb begin
    sum_upd = sum_q;
    sum_upd[row_addr[3:0]*4 +: 4] = upd_stat.avail;
  end

  assign page_ext = {15'd0, row_addr, upd_stat.byte_sel, upd_stat.bit_pos};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (init_cnt == INIT_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (in_kind == KIND_ACQUIRE) begin
            state_next = ST_SCAN;
          end else if (rel_in_map) begin
            state_next = ST_REL;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          state_next = ST_PICK;
        end else if (scan_idx == SCAN_LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_PICK: state_next = ST_DONE;
      ST_REL:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

  // Memory ports and handshake outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    map_we = 1'b0;
    map_wa = row_addr;
    map_wd = row_new;
    map_ra = row_addr;
    sum_we = 1'b0;
    sum_wa = row_addr[ROW_AW-1:4];
    sum_wd = sum_upd;
    sum_ra = scan_idx;
    unique case (state)
      ST_INIT: begin
        map_we = 1'b1;
        map_wa = init_cnt;
        map_wd = init_row;
        sum_we = (init_cnt[3:0] == 4'hF);
        sum_wa = init_cnt[ROW_AW-1:4];
        sum_wd = sum_acc_next;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        map_ra = rel_row;
        sum_ra = (in_kind == KIND_RELEASE) ? rel_row[ROW_AW-1:4] : '0;
      end
      ST_SCAN: begin
        // On a hit the same entry is read again so it is at hand for the write back.
        map_ra = {scan_idx, hit_row};
        sum_ra = scan_hit ? scan_idx : scan_idx + 1'b1;
      end
      ST_PICK, ST_REL: begin
        map_we = 1'b1;
        sum_we = 1'b1;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
    end
    sum_q <= sum_mem[sum_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt  <= '0;
      scan_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_INIT: begin
          init_cnt <= init_cnt + 1'b1;
          sum_acc  <= sum_acc_next;
        end
        ST_IDLE: begin
          if (accept) begin
            op_kind     <= in_kind;
            op_code     <= in_code;
            op_page     <= in_page;
            res_granted <= 1'b0;
            res_page    <= '0;
            scan_idx    <= '0;
            row_addr    <= rel_row;
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            row_addr <= {scan_idx, hit_row};
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_PICK: begin
          res_granted <= 1'b1;
          res_page    <= page_ext[14:0];
        end
        default: begin
        end
      endcase

      if (state == ST_DONE && out_free) begin
        out_valid   <= 1'b1;
        out_granted <= res_granted;
        out_page    <= res_page;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_granted;
  assign m_axis_tdata  = {1'b0, out_page};

endmodule

// ===== sv/apba_checker.sv =====
module apba_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // The map is initialized right after reset, so no request is taken then.
  a_no_accept_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !s_axis_tready)
    else $error("request taken during map initialization");

  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result present right after reset");

  // One request at a time: the port closes after each transfer.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while one is in progress");

  a_fail_page_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'h0000)
    else $error("failed or release result carries a page number");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind aligned_page_bitmap_allocator_core apba_checker u_apba_checker (.*);

// ===== verif/aligned_page_bitmap_allocator_core_test.sv =====
module aligned_page_bitmap_allocator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import apba_pkg::*;

  localparam int MAP_BYTES           = 4096;
  localparam int LOW_RESERVED_BYTES  = 8;
  localparam int HIGH_RESERVED_BYTES = 512;

  typedef struct {
    logic       kind;
    logic [1:0] code;
    logic [14:0] page;
  } page_req_t;

  typedef struct {
    logic        granted;
    logic [14:0] page;
  } grant_t;

  typedef struct {
    logic [14:0] page;
    logic [1:0]  code;
  } page_group_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [1:0] group_code, [16:2] release_page, [23:17] zero
  logic        s_axis_tuser;   // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [14:0] first_page, [15] zero
  logic        m_axis_tuser;   // [0] granted

  logic [7:0]  shadow_map [MAP_BYTES];
  page_req_t   request_q[$];
  grant_t      pending_grants[$];
  page_group_t live_groups[$];

  logic s_took;
  int   in_flight;
  int   err_count;
  int   send_idle_pct;
  int   recv_idle_pct;

  aligned_page_bitmap_allocator_core #(
    .MAP_BYTES          (MAP_BYTES),
    .LOW_RESERVED_BYTES (LOW_RESERVED_BYTES),
    .HIGH_RESERVED_BYTES(HIGH_RESERVED_BYTES)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_shadow_map();
    for (int n = 0; n < MAP_BYTES; n++) begin
      if (n < LOW_RESERVED_BYTES || n >= MAP_BYTES - HIGH_RESERVED_BYTES) begin
        shadow_map[n] = BYTE_FULL;
      end else begin
        shadow_map[n] = 8'h00;
      end
    end
  endfunction

  // Updates the shadow map for one request and returns the result it must produce.
  function automatic grant_t apply_request(input logic kind, input logic [1:0] code,
                                           input logic [14:0] page);
    grant_t      res;
    int          span;
    int          n;
    int          b;
    logic [7:0]  mask;
    logic [15:0] wide;
    page_group_t grp;
    res  = '{1'b0, 15'd0};
    span = 1 << code;
    mask = 8'((9'd1 << span) - 9'd1);
    if (kind == KIND_ACQUIRE) begin
      for (n = 0; n < MAP_BYTES && !res.granted; n++) begin
        if (shadow_map[n] != BYTE_FULL) begin
          for (b = 0; b < 8 && !res.granted; b += span) begin
            if (((shadow_map[n] >> b) & mask) == 8'h00) begin
              shadow_map[n] = shadow_map[n] | 8'(mask << b);
              res.granted = 1'b1;
              res.page = 15'(n * 8 + b);
            end
          end
        end
      end
      if (res.granted) begin
        grp.page = res.page;
        grp.code = code;
        live_groups.push_back(grp);
      end
    end else begin
      // Bits shifted past the top of the byte are simply lost.
      wide = 16'(mask) << page[2:0];
      shadow_map[page[14:3]] = shadow_map[page[14:3]] & ~wide[7:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
  endtask

  task automatic push_req(input logic kind, input logic [1:0] code, input logic [14:0] page);
    page_req_t r;
    r.kind = kind;
    r.code = code;
    r.page = page;
    request_q.push_back(r);
    in_flight++;
  endtask

  task automatic wait_all_done();
    wait (in_flight == 0);
    @(negedge clk);
  endtask

  // Mostly acquires and releases of groups handed out earlier, plus stray releases.
  task automatic queue_random(input int count);
    int          i;
    int          pick;
    int          idx;
    page_group_t grp;
    logic [14:0] pg;
    logic [1:0]  cd;
    for (i = 0; i < count; i++) begin
      while (request_q.size() >= 4) @(negedge clk);
      pick = $urandom_range(99);
      if (pick < 45) begin
        push_req(KIND_ACQUIRE, 2'($urandom_range(3)), 15'($urandom));
      end else if (pick < 85 && live_groups.size() != 0) begin
        idx = $urandom_range(live_groups.size() - 1);
        grp = live_groups[idx];
        live_groups.delete(idx);
        pg = grp.page;
        cd = grp.code;
        if ($urandom_range(9) == 0) pg[2:0] = 3'($urandom);
        if ($urandom_range(9) == 0) cd = 2'($urandom);
        push_req(KIND_RELEASE, cd, pg);
      end else begin
        push_req(KIND_RELEASE, 2'($urandom), 15'($urandom));
      end
    end
  endtask

  always @(negedge clk) begin : drive
    page_req_t r;
    if (!rst) begin
      if (!s_axis_tvalid || s_took) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          r = request_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= r.kind;
          s_axis_tdata  <= {7'd0, r.page, r.code};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watch
    grant_t want;
    if (rst) begin
      s_took <= 1'b0;
    end else begin
      s_took <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        pending_grants.push_back(apply_request(s_axis_tuser, s_axis_tdata[1:0],
                                               s_axis_tdata[16:2]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_grants.size() == 0) begin
          report_mismatch("result transfer with no request outstanding");
        end else begin
          want = pending_grants.pop_front();
          in_flight--;
          if (m_axis_tuser !== want.granted) begin
            report_mismatch($sformatf("granted %b, expected %b (page %0d)",
                                      m_axis_tuser, want.granted, want.page));
          end
          if (m_axis_tdata !== {1'b0, want.page}) begin
            report_mismatch($sformatf("first_page word %h, expected %h",
                                      m_axis_tdata, {1'b0, want.page}));
          end
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : main
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    s_took        = 1'b0;
    in_flight     = 0;
    err_count     = 0;
    send_idle_pct = 19;
    recv_idle_pct = 75;
    reset_shadow_map();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill the first free byte with every group size, then check page zero
    // and releases that run off the end of their byte.
    push_req(KIND_ACQUIRE, GRP_ONE,   15'd0);
    push_req(KIND_ACQUIRE, GRP_TWO,   15'h7FFF);
    push_req(KIND_ACQUIRE, GRP_FOUR,  15'd0);
    push_req(KIND_ACQUIRE, GRP_EIGHT, 15'h5555);
    push_req(KIND_ACQUIRE, GRP_ONE,   15'h2AAA);
    push_req(KIND_RELEASE, GRP_EIGHT, 15'd0);
    push_req(KIND_ACQUIRE, GRP_ONE,   15'd0);
    push_req(KIND_ACQUIRE, GRP_EIGHT, 15'd0);
    push_req(KIND_RELEASE, GRP_FOUR,  15'd70);
    push_req(KIND_ACQUIRE, GRP_TWO,   15'd0);
    push_req(KIND_ACQUIRE, GRP_TWO,   15'd0);
    push_req(KIND_RELEASE, GRP_TWO,   15'd3);
    push_req(KIND_ACQUIRE, GRP_FOUR,  15'd0);
    push_req(KIND_RELEASE, GRP_EIGHT, 15'h7FFF);
    push_req(KIND_RELEASE, GRP_TWO,   15'd32760);
    push_req(KIND_RELEASE, GRP_ONE,   15'd0);
    push_req(KIND_ACQUIRE, GRP_ONE,   15'd0);
    push_req(KIND_RELEASE, GRP_EIGHT, 15'd77);
    push_req(KIND_ACQUIRE, GRP_EIGHT, 15'd0);

    queue_random(170);
    send_idle_pct = 75;
    recv_idle_pct = 19;
    queue_random(170);

    // Hold the sender back until the block is idle, then send a run of
    // group-of-eight requests back to back with the receiver always ready.
    wait_all_done();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 40; i++) begin
      push_req(KIND_ACQUIRE, GRP_EIGHT, 15'($urandom));
    end
    wait_all_done();
    push_req(KIND_ACQUIRE, GRP_EIGHT, 15'd0);
    push_req(KIND_ACQUIRE, GRP_FOUR,  15'h7FFF);
    push_req(KIND_ACQUIRE, GRP_TWO,   15'd0);
    push_req(KIND_ACQUIRE, GRP_ONE,   15'd0);
    queue_random(100);

    wait_all_done();
    repeat (40) @(negedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
